FILE: hw/rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range minimum segment tree: word formats,
// operation codes and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package rmst_pkg;

  // value of an empty node
  localparam logic [29:0] EMPTY_VALUE = 30'd1000000000;

  // operation codes
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  position;
    logic [29:0] value;
    logic [9:0]  query_low;
    logic [9:0]  query_high;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [29:0] minimum;
    logic        range_error;
  } out_word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted input word
    logic clr_start;   // restart the clearing sweep at node 0
    logic clr_step;    // clear one node
    logic leaf_write;  // write the leaf, read its sibling
    logic up_step;     // write one ancestor, read the next sibling
    logic q_left;      // left edge step of the query walk
    logic q_right;     // right edge step and level shift
    logic q_fold;      // fold the last pending read into the minimum
    logic out_load;    // move the query result into the output register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;      // mode of the word on the input port
    logic       pos_ok;    // update position lies inside the tree
    logic       clr_last;  // sweep is on the last node
    logic       up_last;   // parent of the current node is the root
    logic       l_lt_r;    // query walk still has nodes to visit
  } dp_sts_t;

endpackage

FILE: hw/rtl/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl
// Controller of the segment tree: accepts words, sequences clear sweeps,
// leaf-to-root updates and the query walk along both range edges, and owns the result valid.
// ----------------------------------------------------------------------------
module rmst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rmst_pkg::dp_cmd_t cmd,
  input  rmst_pkg::dp_sts_t sts
);

  // state codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CLEAR   = 3'd1;
  localparam logic [2:0] ST_U_LEAF  = 3'd2;
  localparam logic [2:0] ST_U_WRITE = 3'd3;
  localparam logic [2:0] ST_Q_LEFT  = 3'd4;
  localparam logic [2:0] ST_Q_RIGHT = 3'd5;
  localparam logic [2:0] ST_Q_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.mode)
            rmst_pkg::MODE_UPDATE: state_nxt = sts.pos_ok ? ST_U_LEAF : ST_IDLE;
            rmst_pkg::MODE_QUERY:  state_nxt = ST_Q_LEFT;
            rmst_pkg::MODE_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_U_LEAF: begin
        cmd.leaf_write = 1'b1;
        state_nxt      = ST_U_WRITE;
      end
      ST_U_WRITE: begin
        cmd.up_step = 1'b1;
        if (sts.up_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_Q_LEFT: begin
        if (sts.l_lt_r) begin
          cmd.q_left = 1'b1;
          state_nxt  = ST_Q_RIGHT;
        end else begin
          cmd.q_fold = 1'b1;
          state_nxt  = ST_Q_DONE;
        end
      end
      ST_Q_RIGHT: begin
        cmd.q_right = 1'b1;
        state_nxt   = ST_Q_LEFT;
      end
      ST_Q_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state registers, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // a clear word leads into the sweep
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.mode == rmst_pkg::MODE_CLEAR) |=> (state_r == ST_CLEAR))
    else $error("clear did not start the sweep");

  // a taken result without a new one leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !cmd.out_load) |=> !out_valid_r)
    else $error("taken result still valid");

endmodule

FILE: hw/rtl/rmst_datapath.sv
// ----------------------------------------------------------------------------
// rmst_datapath
// Datapath of the segment tree: node memory with one write and one registered
// read port, update and query walk registers, clear counter and result word.
// ----------------------------------------------------------------------------
module rmst_datapath #(
  parameter int LEAVES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmst_pkg::in_word_t  in_data,
  input  rmst_pkg::dp_cmd_t   cmd,
  output rmst_pkg::dp_sts_t   sts,
  output rmst_pkg::out_word_t out_data
);

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = $clog2(NODES + 1);
  localparam logic [31:0] LEAVES_W = 32'(LEAVES);

  // node memory
  logic [29:0] node_mem [NODES];
  logic [29:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [29:0]   wr_data;
  logic          rd_en, wr_en;

  // walk registers
  logic [AW-1:0] idx_r;
  logic [29:0]   cur_r;
  logic [IW-1:0] l_r, r_r;
  logic [29:0]   best_r, best_nxt;
  logic          pend_r;
  logic          err_r;
  logic [AW-1:0] clr_cnt_r;
  rmst_pkg::out_word_t out_data_r;

  // input decode
  logic [31:0]   pos_w, lo_w, hi_w, hi_sat;
  logic          q_skip;
  logic [29:0]   val_sat;
  logic [AW-1:0] parent;
  logic [29:0]   up_min;
  logic [IW-1:0] r_dec;

  assign pos_w   = 32'(in_data.position);
  assign lo_w    = 32'(in_data.query_low);
  assign hi_w    = 32'(in_data.query_high);
  assign hi_sat  = (hi_w >= LEAVES_W) ? (LEAVES_W - 32'd1) : hi_w;
  assign q_skip  = (lo_w > hi_sat);
  assign val_sat = (in_data.value > rmst_pkg::EMPTY_VALUE) ? rmst_pkg::EMPTY_VALUE
                                                           : in_data.value;

  assign parent  = idx_r >> 1;
  assign up_min  = (rd_data_r < cur_r) ? rd_data_r : cur_r;
  assign r_dec   = r_r - IW'(1);

  // status
  assign sts.mode     = in_data.mode;
  assign sts.pos_ok   = (pos_w < LEAVES_W);
  assign sts.clr_last = (clr_cnt_r == AW'(NODES - 1));
  assign sts.up_last  = (parent == AW'(1));
  assign sts.l_lt_r   = (l_r < r_r);

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = rmst_pkg::EMPTY_VALUE;
    rd_en   = 1'b0;
    rd_addr = idx_r ^ AW'(1);
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end
    if (cmd.leaf_write) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = cur_r;
      rd_en   = 1'b1;
    end
    if (cmd.up_step) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = up_min;
      rd_en   = 1'b1;
      rd_addr = parent ^ AW'(1);
    end
    if (cmd.q_left) begin
      rd_en   = l_r[0];
      rd_addr = l_r[AW-1:0];
    end
    if (cmd.q_right) begin
      rd_en   = r_r[0];
      rd_addr = r_dec[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= node_mem[rd_addr];
    end
  end

  // running query minimum, folds the node read in the previous step
  always_comb begin
    best_nxt = best_r;
    if (cmd.load) begin
      best_nxt = rmst_pkg::EMPTY_VALUE;
    end else if ((cmd.q_left || cmd.q_right || cmd.q_fold) && pend_r &&
                 (rd_data_r < best_r)) begin
      best_nxt = rd_data_r;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    if (cmd.load) begin
      idx_r  <= AW'(pos_w + LEAVES_W);
      cur_r  <= val_sat;
      err_r  <= (in_data.query_low > in_data.query_high);
      pend_r <= 1'b0;
      if (q_skip) begin
        l_r <= '0;
        r_r <= '0;
      end else begin
        l_r <= IW'(lo_w + LEAVES_W);
        r_r <= IW'(hi_sat + LEAVES_W + 32'd1);
      end
    end
    if (cmd.up_step) begin
      idx_r <= parent;
      cur_r <= up_min;
    end
    if (cmd.q_left) begin
      pend_r <= l_r[0];
      if (l_r[0]) begin
        l_r <= l_r + IW'(1);
      end
    end
    if (cmd.q_right) begin
      pend_r <= r_r[0];
      l_r    <= l_r >> 1;
      r_r    <= r_r >> 1;
    end
    if (cmd.q_fold) begin
      pend_r <= 1'b0;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.minimum     <= best_r;
      out_data_r.range_error <= err_r;
    end
  end

  assign out_data = out_data_r;

  // query walk keeps left edge at or below right edge
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.q_left || cmd.q_right) |-> (l_r <= r_r))
    else $error("query walk edges crossed");

  // upward walk never runs from the root
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.up_step |-> (idx_r > AW'(1)))
    else $error("update walked past the root");

  // a reversed range reports the empty value
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && err_r) |-> (best_r == rmst_pkg::EMPTY_VALUE))
    else $error("range error with a non-empty minimum");

endmodule

FILE: hw/rtl/range_minimum_segment_tree.sv
// ----------------------------------------------------------------------------
// range_minimum_segment_tree
// Update: the word is taken, then one leaf write and log2(LEAVES) ancestor
// writes; a position outside the tree is dropped. No word is taken meanwhile.
// Query: a left and a right edge step per level for up to log2(LEAVES)+1
// levels, then a fold; out_valid rises as the result is loaded and a new word
// can be taken in that cycle; the load waits while out_stall holds a result.
// Clear and reset: a sweep over all 2*LEAVES nodes, one node per cycle, in_stall high.
// ----------------------------------------------------------------------------
module range_minimum_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmst_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmst_pkg::out_word_t out_data
);

  rmst_pkg::dp_cmd_t cmd;
  rmst_pkg::dp_sts_t sts;

  // sequencer
  rmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // node memory and walk registers
  rmst_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
